### src/wfc_pkg.sv
// types, constants and helper functions for the waypoint follow controller
// used by waypoint_follow_controller and the testbench; depends on nothing

package wfc_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int CW = 38;
  localparam int AW_ANG = 18;

  localparam logic signed [AW_ANG-1:0] Q13_PI = 18'sd25736;
  localparam logic signed [AW_ANG-1:0] Q13_HALF_PI = 18'sd12868;
  localparam logic [15:0] STICTION_Q12 = 16'd1229;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [15:0] RECIP3_Q16 = 16'd21846;

  localparam logic [15:0] GOAL_TOL_RESET = 16'd1229;
  localparam logic [14:0] HEAD_TOL_RESET = 15'd1430;
  localparam logic [14:0] FWD_LIMIT_RESET = 15'd819;
  localparam logic [14:0] TURN_LIMIT_RESET = 15'd819;

  localparam logic [1:0] REG_GOAL_TOL = 2'd0;
  localparam logic [1:0] REG_HEAD_TOL = 2'd1;
  localparam logic [1:0] REG_FWD_LIMIT = 2'd2;
  localparam logic [1:0] REG_TURN_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_APPEND = 2'd1,
    OP_POSE = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POSE_MUL,
    ST_READ,
    ST_SETUP,
    ST_CORDIC,
    ST_ANGLE,
    ST_DECIDE,
    ST_DIVF,
    ST_POST,
    ST_DIVT,
    ST_FINISH,
    ST_DONE
  } state_t;

  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    logic [12:0] r;
    begin
      unique case (i)
        4'd0: r = 13'd6434;
        4'd1: r = 13'd3798;
        4'd2: r = 13'd2007;
        4'd3: r = 13'd1019;
        4'd4: r = 13'd511;
        4'd5: r = 13'd256;
        4'd6: r = 13'd128;
        4'd7: r = 13'd64;
        4'd8: r = 13'd32;
        4'd9: r = 13'd16;
        4'd10: r = 13'd8;
        4'd11: r = 13'd4;
        4'd12: r = 13'd2;
        4'd13: r = 13'd1;
        default: r = 13'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [AW_ANG-1:0] wrap_angle(input logic signed [AW_ANG-1:0] a);
    logic signed [AW_ANG-1:0] v;
    begin
      v = a;
      for (int k = 0; k < 3; k++) begin
        if (v > Q13_PI) begin
          v = v - (Q13_PI <<< 1);
        end else if (v <= -Q13_PI) begin
          v = v + (Q13_PI <<< 1);
        end
      end
      return v;
    end
  endfunction

endpackage

### src/wfc_ram.sv
// generic single write port ram with registered read
// depends on nothing

module wfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/waypoint_follow_controller.sv
// top level of the waypoint follow controller: plan queue, pose, cordic and divider
// depends on wfc_pkg and wfc_ram
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------------
//  input     | in_valid, in_stall  | opcode, pos_x, pos_y, quat_x..quat_w
//  output    | out_valid, out_stall| fwd_cmd, turn_cmd, cmd_valid, plan_empty
//  config    | cfg_we              | cfg_index, cfg_data
//
// one request at a time: clear and append go straight on to hand over the result; a pose
// update runs the quaternion products, setup, 14 cordic steps and the angle; compute tests
// each waypoint (ram read, setup, 14 cordic steps, scaling, decision), then reads once more
// when the plan runs empty or runs up to two 15 step divisions, and hands over the result
// reset empties the plan, zeroes the pose and loads the register defaults
// in_stall is high while a request is at work or its result waits behind a stalled one

module waypoint_follow_controller import wfc_pkg::*; #(
  parameter int PLAN_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] fwd_cmd,
  output logic signed [15:0] turn_cmd,
  output logic               cmd_valid,
  output logic               plan_empty
);

  localparam int AW = $clog2(PLAN_DEPTH);
  localparam int NW = AW + 1;
  localparam logic [NW-1:0] DEPTH_N = NW'(PLAN_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(PLAN_DEPTH - 1);

  state_t state, state_next;

  logic [15:0] goal_tol;
  logic [14:0] heading_tolerance;
  logic [14:0] forward_limit;
  logic [14:0] turn_limit;

  logic [AW-1:0] queue_head;
  logic [NW-1:0] queue_count;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [15:0] robot_yaw;
  logic forward_flag;

  opcode_t op;
  logic signed [31:0] px, py;
  logic signed [15:0] qx, qy, qz, qw;

  logic [3:0] cnt;
  logic signed [31:0] prod;
  logic signed [32:0] acc_num;
  logic signed [32:0] acc_den;

  logic signed [CW-1:0] cx, cy;
  logic signed [AW_ANG-1:0] cz;
  logic zero_vec;

  logic [34:0] wp_dist;
  logic signed [AW_ANG-1:0] err;
  logic ncc;

  logic [35:0] div_rem;
  logic [34:0] div_den;
  logic [14:0] div_q;
  logic [14:0] pf;
  logic [14:0] tmag;

  logic signed [15:0] res_fwd;
  logic signed [15:0] res_turn;
  logic res_cmd;

  logic in_acc;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0] ram_rdata;

  // combinational helpers
  logic [NW:0] tail_sum;
  logic [AW-1:0] tail;
  logic signed [CW-1:0] sx, sy;
  logic signed [CW-1:0] xs, ys;
  logic [12:0] atan_i;
  logic signed [15:0] mul_a, mul_b;
  logic [CW-1:0] mag;
  logic signed [AW_ANG-1:0] hdg;
  logic [15:0] aerr;
  logic [19:0] gq16;
  logic close, reach, far, straight, turn_sat;
  logic div_ge;
  logic [14:0] div_q_next;
  logic signed [15:0] turn_val;
  logic [30:0] third;
  logic [15:0] fwd_val;
  logic [AW_ANG-1:0] two_h;

  assign in_acc = in_valid && !in_stall;

  wfc_ram #(.WIDTH(64), .DEPTH(PLAN_DEPTH)) u_plan (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pos_x, pos_y}),
    .raddr (queue_head),
    .rdata (ram_rdata)
  );

  always_comb begin
    tail_sum = (NW+1)'(queue_head) + (NW+1)'(queue_count);
    if (tail_sum >= (NW+1)'(PLAN_DEPTH)) begin
      tail = AW'(tail_sum - (NW+1)'(PLAN_DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  always_comb begin
    if (op == OP_POSE) begin
      sx = CW'(acc_den);
      sy = CW'(acc_num) <<< 1;
    end else begin
      sx = CW'($signed(ram_rdata[63:32])) - CW'(robot_x);
      sy = CW'($signed(ram_rdata[31:0])) - CW'(robot_y);
    end
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    atan_i = atan_q13(cnt);
  end

  always_comb begin
    case (cnt)
      4'd0: begin mul_a = qw; mul_b = qz; end
      4'd1: begin mul_a = qx; mul_b = qy; end
      4'd2: begin mul_a = qw; mul_b = qw; end
      4'd3: begin mul_a = qx; mul_b = qx; end
      4'd4: begin mul_a = qy; mul_b = qy; end
      default: begin mul_a = qz; mul_b = qz; end
    endcase
  end

  always_comb begin
    mag = zero_vec ? '0 : cx;
    hdg = zero_vec ? '0 : wrap_angle(cz);
    aerr = err[AW_ANG-1] ? 16'(-err) : 16'(err);
    gq16 = {goal_tol, 4'b0};
    close = wp_dist <= 35'(gq16);
    ncc = {1'b0, wp_dist, 1'b0} < 37'(22'(gq16) * 22'd3);
    reach = close || (ncc && ($signed({2'b0, aerr}) > Q13_HALF_PI));
    far = wp_dist >= 35'({goal_tol, 5'b0});
    straight = ncc || (aerr <= 16'(heading_tolerance));
    turn_sat = aerr >= {heading_tolerance, 1'b0};
    div_ge = {1'b0, div_den} <= div_rem;
    div_q_next = {div_q[13:0], div_ge};
    two_h = AW_ANG'({heading_tolerance, 1'b0});
    third = 31'(pf) * 31'(RECIP3_Q16);
    if (!forward_flag || (err > $signed(two_h))) begin
      fwd_val = '0;
    end else begin
      fwd_val = 16'(third[30:16]);
    end
    if (tmag < STICTION_Q12[14:0]) begin
      if (!err[AW_ANG-1] && (err != '0) && (tmag != '0)) begin
        turn_val = $signed(STICTION_Q12);
      end else begin
        turn_val = -$signed(STICTION_Q12);
      end
    end else if (err[AW_ANG-1]) begin
      turn_val = -$signed({1'b0, tmag});
    end else begin
      turn_val = $signed({1'b0, tmag});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode_t'(opcode))
            OP_POSE: state_next = ST_POSE_MUL;
            OP_COMPUTE: state_next = ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_POSE_MUL: if (cnt == 4'd6) state_next = ST_SETUP;
      ST_READ: state_next = (queue_count == '0) ? ST_DONE : ST_SETUP;
      ST_SETUP: state_next = ST_CORDIC;
      ST_CORDIC: if (cnt == 4'(CORDIC_STEPS - 1)) state_next = ST_ANGLE;
      ST_ANGLE: state_next = (op == OP_POSE) ? ST_DONE : ST_DECIDE;
      ST_DECIDE: begin
        if (reach) begin
          state_next = ST_READ;
        end else if (far) begin
          state_next = ST_POST;
        end else begin
          state_next = ST_DIVF;
        end
      end
      ST_DIVF: if (cnt == 4'd14) state_next = ST_POST;
      ST_POST: begin
        if (straight) begin
          state_next = ST_DONE;
        end else if (turn_sat) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIVT;
        end
      end
      ST_DIVT: if (cnt == 4'd14) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall = (state != ST_IDLE);
    ram_we = (state == ST_IDLE) && in_valid && (opcode_t'(opcode) == OP_APPEND) &&
             (queue_count < DEPTH_N);
    ram_waddr = tail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_tol <= GOAL_TOL_RESET;
      heading_tolerance <= HEAD_TOL_RESET;
      forward_limit <= FWD_LIMIT_RESET;
      turn_limit <= TURN_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL_TOL: goal_tol <= cfg_data;
        REG_HEAD_TOL: heading_tolerance <= cfg_data[14:0];
        REG_FWD_LIMIT: forward_limit <= cfg_data[14:0];
        REG_TURN_LIMIT: turn_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // queue, pose and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head <= '0;
      queue_count <= '0;
      robot_x <= '0;
      robot_y <= '0;
      robot_yaw <= '0;
      forward_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_acc) begin
        if (opcode_t'(opcode) == OP_CLEAR) begin
          queue_head <= '0;
          queue_count <= '0;
        end else if (ram_we) begin
          queue_count <= queue_count + 1'b1;
        end
      end
      if (state == ST_ANGLE && op == OP_POSE) begin
        robot_x <= px;
        robot_y <= py;
        robot_yaw <= 16'(hdg);
      end
      if (state == ST_DECIDE && reach) begin
        queue_head <= (queue_head == LAST_IDX) ? '0 : queue_head + 1'b1;
        queue_count <= queue_count - 1'b1;
        forward_flag <= 1'b0;
      end
      if (state == ST_POST && straight) begin
        forward_flag <= 1'b1;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      fwd_cmd <= res_fwd;
      turn_cmd <= res_turn;
      cmd_valid <= res_cmd;
      plan_empty <= (queue_count == '0);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op <= opcode_t'(opcode);
        px <= pos_x;
        py <= pos_y;
        qx <= quat_x;
        qy <= quat_y;
        qz <= quat_z;
        qw <= quat_w;
        cnt <= '0;
        acc_num <= '0;
        acc_den <= '0;
        res_fwd <= '0;
        res_turn <= '0;
        res_cmd <= 1'b0;
      end
      ST_POSE_MUL: begin
        prod <= 32'(mul_a) * 32'(mul_b);
        case (cnt)
          4'd1, 4'd2: acc_num <= acc_num + prod;
          4'd3, 4'd4: acc_den <= acc_den + prod;
          4'd5, 4'd6: acc_den <= acc_den - prod;
          default: ;
        endcase
        cnt <= cnt + 1'b1;
      end
      ST_SETUP: begin
        zero_vec <= (sx == '0) && (sy == '0);
        cnt <= '0;
        if (sx[CW-1]) begin
          if (!sy[CW-1]) begin
            cx <= sy;
            cy <= -sx;
            cz <= Q13_HALF_PI;
          end else begin
            cx <= -sy;
            cy <= sx;
            cz <= -Q13_HALF_PI;
          end
        end else begin
          cx <= sx;
          cy <= sy;
          cz <= '0;
        end
      end
      ST_CORDIC: begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + AW_ANG'(atan_i);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - AW_ANG'(atan_i);
        end
        cnt <= cnt + 1'b1;
      end
      ST_ANGLE: begin
        wp_dist <= 35'((51'(mag[34:0]) * 51'(INV_GAIN_Q16)) >> 16);
        err <= wrap_angle(AW_ANG'(robot_yaw) - hdg);
      end
      ST_DECIDE: begin
        cnt <= '0;
        div_q <= '0;
        pf <= forward_limit;
        div_rem <= 36'(wp_dist[20:0]) * 36'(forward_limit);
        div_den <= {21'({goal_tol, 5'b0}), 14'b0};
      end
      ST_DIVF, ST_DIVT: begin
        if (div_ge) begin
          div_rem <= div_rem - {1'b0, div_den};
        end
        div_den <= div_den >> 1;
        div_q <= div_q_next;
        cnt <= cnt + 1'b1;
        if (cnt == 4'd14) begin
          if (state == ST_DIVF) begin
            pf <= div_q_next;
          end else begin
            tmag <= div_q_next;
          end
        end
      end
      ST_POST: begin
        cnt <= '0;
        div_q <= '0;
        tmag <= turn_limit;
        div_rem <= 36'(aerr) * 36'(turn_limit);
        div_den <= {21'({heading_tolerance, 1'b0}), 14'b0};
        if (straight) begin
          res_fwd <= $signed({1'b0, pf});
          res_turn <= '0;
          res_cmd <= 1'b1;
        end
      end
      ST_FINISH: begin
        res_fwd <= $signed(fwd_val);
        res_turn <= turn_val;
        res_cmd <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### dv/tb_waypoint_follow_controller.sv
// self-checking testbench for waypoint_follow_controller: directed and random
// requests checked against a bit-true predictor of the controller
// depends on wfc_pkg and the rtl in src

module tb_waypoint_follow_controller;
  import wfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam longint ANG_PI = 25736;
  localparam longint ANG_HALF_PI = 12868;
  localparam longint STICTION = 1229;
  localparam longint LEN_GAIN = 39797;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
    logic               valid;
    logic               empty;
  } command_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] fwd_cmd, turn_cmd;
  logic cmd_valid, plan_empty;

  waypoint_follow_controller DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .pos_x(pos_x),
    .pos_y(pos_y), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .out_valid(out_valid), .out_stall(out_stall), .fwd_cmd(fwd_cmd),
    .turn_cmd(turn_cmd), .cmd_valid(cmd_valid), .plan_empty(plan_empty)
  );

  // predictor state
  longint wp_x[DEPTH];
  longint wp_y[DEPTH];
  int unsigned q_head, q_count;
  longint pose_x, pose_y, pose_yaw;
  bit driving_fwd;
  longint goal_tol, head_tol, fwd_lim, turn_lim;
  longint angle_step[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4,
                             2, 1};

  command_t pending_cmds[$];
  int failures;
  bit calm;
  int hold_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd400_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint wrap_pi(input longint a);
    longint v;
    v = a;
    for (int k = 0; k < 3; k++) begin
      if (v > ANG_PI) begin
        v -= 2 * ANG_PI;
      end else if (v <= -ANG_PI) begin
        v += 2 * ANG_PI;
      end
    end
    return v;
  endfunction

  task automatic vector_polar(input longint xi, input longint yi, output longint ang,
                              output longint mag);
    longint x, y, z, t, xs, ys;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ANG_HALF_PI;
      end else begin
        x = -y; y = t; z = -ANG_HALF_PI;
      end
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += angle_step[i];
      end else begin
        x = x - ys; y = y + xs; z -= angle_step[i];
      end
    end
    ang = wrap_pi(z);
    mag = x;
  endtask

  task automatic predict_command(input opcode_t op, input longint px, input longint py,
                                 input longint qx, input longint qy, input longint qz,
                                 input longint qw, output command_t res);
    longint hdg, mag, wp_dist, err, aerr, gq, pf, p, num, den;
    int unsigned h;
    bit near_goal, reached_band;
    res = '0;
    case (op)
      OP_CLEAR: begin
        q_head = 0;
        q_count = 0;
      end
      OP_APPEND: begin
        if (q_count < DEPTH) begin
          wp_x[(q_head + q_count) % DEPTH] = px;
          wp_y[(q_head + q_count) % DEPTH] = py;
          q_count++;
        end
      end
      OP_POSE: begin
        num = 2 * (qw * qz + qx * qy);
        den = qw * qw + qx * qx - qy * qy - qz * qz;
        vector_polar(den, num, hdg, mag);
        pose_x = px;
        pose_y = py;
        pose_yaw = hdg;
      end
      default: begin
        while (q_count > 0) begin
          h = q_head % DEPTH;
          vector_polar(wp_x[h] - pose_x, wp_y[h] - pose_y, hdg, mag);
          wp_dist = (mag * LEN_GAIN) >>> 16;
          err = wrap_pi(pose_yaw - hdg);
          aerr = err < 0 ? -err : err;
          gq = goal_tol * 16;
          near_goal = wp_dist <= gq;
          reached_band = 2 * wp_dist < 3 * gq;
          if (near_goal || (reached_band && aerr > ANG_HALF_PI)) begin
            q_head = (h + 1) % DEPTH;
            q_count--;
            driving_fwd = 1'b0;
            continue;
          end
          if (goal_tol == 0) pf = fwd_lim;
          else pf = (wp_dist * fwd_lim) / (32 * goal_tol);
          if (pf > fwd_lim) pf = fwd_lim;
          res.valid = 1'b1;
          if (reached_band || aerr <= head_tol) begin
            res.fwd = pf;
            res.turn = 0;
            driving_fwd = 1'b1;
          end else begin
            p = (err * turn_lim) / (2 * head_tol);
            if (p > turn_lim) p = turn_lim;
            if (p < -turn_lim) p = -turn_lim;
            if ((p < 0 ? -p : p) < STICTION) p = p > 0 ? STICTION : -STICTION;
            res.turn = p;
            res.fwd = (!driving_fwd || err > 2 * head_tol) ? 0 : pf / 3;
          end
          break;
        end
      end
    endcase
    res.empty = (q_count == 0);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  task automatic send_request(input opcode_t op, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic signed [15:0] qx,
                              input logic signed [15:0] qy, input logic signed [15:0] qz,
                              input logic signed [15:0] qw);
    int gap;
    command_t res;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    pos_x <= px;
    pos_y <= py;
    quat_x <= qx;
    quat_y <= qy;
    quat_z <= qz;
    quat_w <= qw;
    do @(posedge clk); while (in_stall);
    predict_command(op, px, py, qx, qy, qz, qw, res);
    pending_cmds.insert(pending_cmds.size(), res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GOAL_TOL: goal_tol = data;
      REG_HEAD_TOL: head_tol = data[14:0];
      REG_FWD_LIMIT: fwd_lim = data[14:0];
      default: turn_lim = data[14:0];
    endcase
  endtask

  task automatic set_limits(input logic [15:0] g, input logic [15:0] h,
                            input logic [15:0] f, input logic [15:0] t);
    write_reg(REG_GOAL_TOL, g);
    write_reg(REG_HEAD_TOL, h);
    write_reg(REG_FWD_LIMIT, f);
    write_reg(REG_TURN_LIMIT, t);
  endtask

  function automatic logic signed [15:0] rand_quat();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic signed [31:0] near(input longint base, input longint span);
    return 32'(base + longint'($urandom_range(0, 32'(2 * span))) - span);
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    command_t exp_cmd;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result fwd_cmd=%0d turn_cmd=%0d", fwd_cmd, turn_cmd);
        failures++;
      end else begin
        exp_cmd = pending_cmds[0];
        pending_cmds.delete(0);
        if (fwd_cmd !== exp_cmd.fwd) begin
          $error("fwd_cmd expected %0d actual %0d", exp_cmd.fwd, fwd_cmd);
          failures++;
        end
        if (turn_cmd !== exp_cmd.turn) begin
          $error("turn_cmd expected %0d actual %0d", exp_cmd.turn, turn_cmd);
          failures++;
        end
        if (cmd_valid !== exp_cmd.valid) begin
          $error("cmd_valid expected %0d actual %0d", exp_cmd.valid, cmd_valid);
          failures++;
        end
        if (plan_empty !== exp_cmd.empty) begin
          $error("plan_empty expected %0d actual %0d", exp_cmd.empty, plan_empty);
          failures++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0);
    send_request(OP_APPEND, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_POSE, 32'sh80000000, 32'sh7fffffff, 16384, -16384, 16384, -16384);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_POSE, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_POSE, 0, 0, -16384, 16384, -16384, 16384);
    send_request(OP_APPEND, 32'sh00080000, 32'sh00001000, 0, 0, 0, 0);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_POSE, 32'sh00080000, 32'sh00001000, 0, 0, 16384, 0);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_APPEND, -32'sh00030000, 32'sh00030000, 0, 0, 0, 0);
    send_request(OP_POSE, 0, 0, 0, 0, 0, 16384);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_CLEAR, 32'sh7fffffff, 32'sh80000000, 16384, 16384, 16384, 16384);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_full_plan();
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_request(OP_APPEND, i * 32'sh00004000, -i * 32'sh00002000, 0, 0, 0, 0);
    end
    send_request(OP_POSE, 32'sh00200000, 0, 0, 0, 0, 16384);
    send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_missions(input int n_items);
    int sent, k, j;
    longint span, base_x, base_y;
    longint wx[$];
    longint wy[$];
    logic signed [31:0] rx, ry;
    sent = 0;
    while (sent < n_items) begin
      span = ($urandom_range(0, 3) == 0) ? 64'd1048576 : goal_tol * 48 + 256;
      base_x = near(0, 64'd3000000);
      base_y = near(0, 64'd3000000);
      wx.delete();
      wy.delete();
      if ($urandom_range(0, 4) != 0) begin
        send_request(OP_CLEAR, $urandom(), $urandom(), rand_quat(), rand_quat(),
                     rand_quat(), rand_quat());
        sent++;
      end
      k = ($urandom_range(0, 40) == 0) ? DEPTH : $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
        wx.insert(wx.size(), near(base_x, span));
        wy.insert(wy.size(), near(base_y, span));
        send_request(OP_APPEND, wx[i], wy[i], rand_quat(), rand_quat(), rand_quat(),
                     rand_quat());
        sent++;
      end
      repeat ($urandom_range(2, 10)) begin
        j = $urandom_range(0, k - 1);
        rx = near(wx[j], span);
        ry = near(wy[j], span);
        if ($urandom_range(0, 1) == 0) begin
          send_request(OP_POSE, rx, ry, 0, 0, rand_quat(), rand_quat());
        end else begin
          send_request(OP_POSE, rx, ry, rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
        send_request(OP_COMPUTE, $urandom(), $urandom(), rand_quat(), rand_quat(),
                     rand_quat(), rand_quat());
        sent += 2;
        if ($urandom_range(0, 7) == 0) begin
          send_request(opcode_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                       rand_quat(), rand_quat(), rand_quat(), rand_quat());
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) begin
      send_request(OP_APPEND, near(0, 64'd200000), near(0, 64'd200000), 0, 0, 0, 0);
      send_request(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
      send_request(OP_POSE, near(0, 64'd100000), near(0, 64'd100000), 0, 0,
                   rand_quat(), rand_quat());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = '0;
    pos_x = '0;
    pos_y = '0;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    quat_w = '0;
    failures = 0;
    calm = 1'b0;
    hold_left = 0;
    q_head = 0;
    q_count = 0;
    pose_x = 0;
    pose_y = 0;
    pose_yaw = 0;
    driving_fwd = 1'b0;
    goal_tol = GOAL_TOL_RESET;
    head_tol = HEAD_TOL_RESET;
    fwd_lim = FWD_LIMIT_RESET;
    turn_lim = TURN_LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_full_plan();
    test_random_missions(250);
    set_limits(16'd65535, 16'd25736, 16'd32767, 16'd32767);
    test_random_missions(200);
    set_limits(16'd1, 16'h8001, 16'h8000, 16'h8000);
    test_basic_ops();
    test_random_missions(200);
    set_limits(16'd0, 16'd700, 16'd32767, 16'd5000);
    test_random_missions(150);
    calm = 1'b1;
    set_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 25736)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    test_random_missions(200);
    calm = 1'b0;
    test_backpressure();
    set_limits(16'd1229, 16'd1430, 16'd819, 16'd819);
    test_random_missions(200);

    drain();
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/wfc_pkg.sv
src/wfc_ram.sv
src/waypoint_follow_controller.sv
dv/tb_waypoint_follow_controller.sv
